// ----- rtl/core/dro_pkg.sv -----
// Shared types, constants and a lookup function for the dead-reckoning odometry block.
// Used by dro_ctrl, dro_datapath and dead_reckoning_odometry; depends on nothing.
package dro_pkg;

  localparam int TrigBitsDefault = 16;
  localparam int AtanCount = 24;
  localparam int IterW = 5;
  localparam int NumRegs = 8;
  localparam int CfgIdxW = 3;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [7:0] ColourStart = 8'd240;
  localparam logic [7:0] FadeStart = 8'd25;
  localparam logic [11:0] PixelMax = 12'd4095;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SPEED_GAIN    = 3'd0,
    REG_TURN_GAIN     = 3'd1,
    REG_BORDER_PIXELS = 3'd2,
    REG_WORLD_X_MIN   = 3'd3,
    REG_WORLD_Y_MIN   = 3'd4,
    REG_X_PIXEL_SCALE = 3'd5,
    REG_Y_PIXEL_SCALE = 3'd6,
    REG_FADE_PERIOD   = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_TURN,
    MUL_SPEED,
    MUL_COS,
    MUL_SIN,
    MUL_PIXX,
    MUL_PIXY
  } mul_sel_e;

  typedef struct packed {
    logic signed [15:0] speed;
    logic [16:0]        turn;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading_out;
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
    logic [7:0]         trail_colour;
  } out_beat_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    logic     head_wr;
    logic     step_wr;
    logic     rot_step;
    logic     x_wr;
    logic     y_wr;
    logic     pixx_wr;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic rot_last;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [33:0] atan_lut(input logic [IterW-1:0] idx);
    logic signed [33:0] v;
    unique case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/dro_ctrl.sv -----
// Sequencer for the odometry update: issues datapath commands step by step.
// Depends on dro_pkg for the command and status structs.
module dro_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dro_pkg::dp_status_t status_i,
  output dro_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_TURN, S_HEAD, S_STEP, S_ROT, S_MULX, S_ADDX, S_ADDY, S_PIXX, S_PIXY
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.mul_sel = dro_pkg::MUL_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_TURN;
        end
      end
      S_TURN: begin
        cmd_o.mul_sel = dro_pkg::MUL_TURN;
        state_d = S_HEAD;
      end
      S_HEAD: begin
        cmd_o.head_wr = 1'b1;
        cmd_o.mul_sel = dro_pkg::MUL_SPEED;
        state_d = S_STEP;
      end
      S_STEP: begin
        cmd_o.step_wr = 1'b1;
        state_d = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot_step = 1'b1;
        if (status_i.rot_last) begin
          state_d = S_MULX;
        end
      end
      S_MULX: begin
        cmd_o.mul_sel = dro_pkg::MUL_COS;
        state_d = S_ADDX;
      end
      S_ADDX: begin
        cmd_o.x_wr = 1'b1;
        cmd_o.mul_sel = dro_pkg::MUL_SIN;
        state_d = S_ADDY;
      end
      S_ADDY: begin
        cmd_o.y_wr = 1'b1;
        cmd_o.mul_sel = dro_pkg::MUL_PIXX;
        state_d = S_PIXX;
      end
      S_PIXX: begin
        cmd_o.pixx_wr = 1'b1;
        cmd_o.mul_sel = dro_pkg::MUL_PIXY;
        state_d = S_PIXY;
      end
      S_PIXY: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- rtl/core/dro_datapath.sv -----
// Datapath of the odometry block: registers, shared multiplier, CORDIC and output register.
// Depends on dro_pkg; driven by dro_ctrl commands.
module dro_datapath #(
  parameter int TRIG_BITS = dro_pkg::TrigBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dro_pkg::dp_cmd_t             cmd_i,
  output dro_pkg::dp_status_t          status_o,
  input  dro_pkg::in_beat_t            in_data_i,
  input  logic                         cfg_we_i,
  input  logic [dro_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output dro_pkg::out_beat_t           out_data_o
);

  localparam int RotN = (TRIG_BITS > dro_pkg::AtanCount) ? dro_pkg::AtanCount : TRIG_BITS;

  logic [15:0]        speed_gain_q, turn_gain_q, xscale_q, yscale_q;
  logic [7:0]         border_q, fade_period_q;
  logic signed [31:0] xmin_q, ymin_q;

  logic [15:0]        heading_q;
  logic signed [31:0] xpos_q, ypos_q;
  logic [7:0]         fade_q, colour_q;

  dro_pkg::in_beat_t  in_q;
  logic [23:0]        step_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic               flip_q;
  logic [dro_pkg::IterW-1:0] iter_q;
  logic signed [59:0] prod_q;
  logic [11:0]        pixx_q;
  logic               out_valid_q;
  dro_pkg::out_beat_t out_q;

  logic signed [34:0] mul_a;
  logic signed [24:0] mul_b;
  logic [16:0]        mag;
  logic signed [34:0] cos_v, sin_v;
  logic signed [34:0] dx, dy;
  logic [24:0]        head_sum;
  logic [15:0]        head_inc;
  logic [15:0]        ang;
  logic signed [33:0] x_sh, y_sh, atan_v;
  logic signed [59:0] pix_sum;
  logic signed [36:0] pix_raw;
  logic [11:0]        pix_sat;
  logic [7:0]         colour_d, fade_d, fade_mid;

  always_comb begin
    mag = in_q.speed[15] ? (17'd0 - {in_q.speed[15], in_q.speed}) : {1'b0, in_q.speed};
    cos_v = flip_q ? -{cx_q[33], cx_q} : {cx_q[33], cx_q};
    sin_v = flip_q ? -{cy_q[33], cy_q} : {cy_q[33], cy_q};
    dx = {{3{xpos_q[31]}}, xpos_q} - {{3{xmin_q[31]}}, xmin_q};
    dy = {{3{ypos_q[31]}}, ypos_q} - {{3{ymin_q[31]}}, ymin_q};
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      dro_pkg::MUL_TURN: begin
        mul_a = {18'd0, in_q.turn};
        mul_b = {9'd0, turn_gain_q};
      end
      dro_pkg::MUL_SPEED: begin
        mul_a = {18'd0, mag};
        mul_b = {9'd0, speed_gain_q};
      end
      dro_pkg::MUL_COS: begin
        mul_a = cos_v;
        mul_b = {1'b0, step_q};
      end
      dro_pkg::MUL_SIN: begin
        mul_a = sin_v;
        mul_b = {1'b0, step_q};
      end
      dro_pkg::MUL_PIXX: begin
        mul_a = dx;
        mul_b = {9'd0, xscale_q};
      end
      dro_pkg::MUL_PIXY: begin
        mul_a = dy;
        mul_b = {9'd0, yscale_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    head_sum = {1'b0, prod_q[23:0]} + 25'd128;
    head_inc = head_sum[23:8];
    ang = heading_q;
    if (heading_q[15] != heading_q[14]) begin
      ang = {~heading_q[15], heading_q[14:0]};
    end
    x_sh = cx_q >>> iter_q;
    y_sh = cy_q >>> iter_q;
    atan_v = dro_pkg::atan_lut(iter_q);
    pix_sum = prod_q + 60'sd8388608;
    pix_raw = {pix_sum[59], pix_sum[59:24]} + {29'd0, border_q};
    if (pix_raw < 0) begin
      pix_sat = 12'd0;
    end else if (pix_raw > 37'sd4095) begin
      pix_sat = dro_pkg::PixelMax;
    end else begin
      pix_sat = pix_raw[11:0];
    end
    colour_d = colour_q;
    fade_mid = fade_q;
    if (fade_q == 8'd0 && colour_q != 8'd0) begin
      colour_d = colour_q - 8'd1;
      fade_mid = fade_period_q;
    end
    fade_d = (fade_mid != 8'd0) ? fade_mid - 8'd1 : fade_mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_gain_q  <= 16'd3282;
      turn_gain_q   <= 16'd168;
      border_q      <= 8'd25;
      xmin_q        <= -32'sd812548;
      ymin_q        <= -32'sd223125;
      xscale_q      <= 16'd4524;
      yscale_q      <= 16'd6251;
      fade_period_q <= 8'd25;
      heading_q     <= '0;
      xpos_q        <= '0;
      ypos_q        <= '0;
      fade_q        <= dro_pkg::FadeStart;
      colour_q      <= dro_pkg::ColourStart;
      iter_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (dro_pkg::reg_idx_e'(cfg_index_i))
          dro_pkg::REG_SPEED_GAIN:    speed_gain_q  <= cfg_data_i[15:0];
          dro_pkg::REG_TURN_GAIN:     turn_gain_q   <= cfg_data_i[15:0];
          dro_pkg::REG_BORDER_PIXELS: border_q      <= cfg_data_i[7:0];
          dro_pkg::REG_WORLD_X_MIN:   xmin_q        <= cfg_data_i;
          dro_pkg::REG_WORLD_Y_MIN:   ymin_q        <= cfg_data_i;
          dro_pkg::REG_X_PIXEL_SCALE: xscale_q      <= cfg_data_i[15:0];
          dro_pkg::REG_Y_PIXEL_SCALE: yscale_q      <= cfg_data_i[15:0];
          dro_pkg::REG_FADE_PERIOD:   fade_period_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.head_wr) begin
        heading_q <= heading_q + head_inc;
      end
      if (cmd_i.step_wr) begin
        iter_q <= '0;
      end else if (cmd_i.rot_step) begin
        iter_q <= iter_q + 1'b1;
      end
      if (cmd_i.x_wr) begin
        xpos_q <= xpos_q + {{2{prod_q[59]}}, prod_q[59:30]};
      end
      if (cmd_i.y_wr) begin
        ypos_q <= ypos_q + {{2{prod_q[59]}}, prod_q[59:30]};
      end
      if (cmd_i.finish) begin
        fade_q      <= fade_d;
        colour_q    <= colour_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.mul_sel != dro_pkg::MUL_NONE) begin
      prod_q <= 60'(mul_a) * 60'(mul_b);
    end
    if (cmd_i.step_wr) begin
      step_q <= prod_q[31:8];
      cx_q   <= dro_pkg::CordicGain;
      cy_q   <= '0;
      cz_q   <= 34'({ang, 16'd0} ^ 32'h0) - ((ang[15]) ? 34'sd4294967296 : 34'sd0);
      flip_q <= (heading_q[15] != heading_q[14]);
    end else if (cmd_i.rot_step) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - y_sh;
        cy_q <= cy_q + x_sh;
        cz_q <= cz_q - atan_v;
      end else begin
        cx_q <= cx_q + y_sh;
        cy_q <= cy_q - x_sh;
        cz_q <= cz_q + atan_v;
      end
    end
    if (cmd_i.pixx_wr) begin
      pixx_q <= pix_sat;
    end
    if (cmd_i.finish) begin
      out_q.pos_x        <= xpos_q;
      out_q.pos_y        <= ypos_q;
      out_q.heading_out  <= heading_q;
      out_q.pixel_x      <= pixx_q;
      out_q.pixel_y      <= pix_sat;
      out_q.trail_colour <= colour_d;
    end
  end

  assign status_o.rot_last = (iter_q == dro_pkg::IterW'(RotN - 1));
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// ----- rtl/core/dead_reckoning_odometry.sv -----
// Top level of the dead-reckoning odometry block: controller plus datapath.
// Depends on dro_pkg, dro_ctrl and dro_datapath.
//
//   channel | direction | handshake           | beat
//   in      | input     | in_valid / stall    | speed, turn
//   out     | output    | out_valid / stall   | position, heading, pixel, colour
//   cfg     | input     | cfg_valid / ready   | register index and 32-bit data
//
// The result beat is registered after the turn, heading, step, CORDIC rotation, x, y and pixel
// steps, in that order; a new item is not accepted while the previous one is in these steps.
// The serial CORDIC rotation, one step per cycle, and the single shared multiplier set this sequence.
// Reset restores all configuration registers and the odometry state at once.
// A new item is accepted only after the previous result has entered the output register.
// A stalled output holds the finished result; the next item then waits in its last step.
module dead_reckoning_odometry #(
  parameter int TRIG_BITS = dro_pkg::TrigBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  dro_pkg::in_beat_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output dro_pkg::out_beat_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dro_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);

  dro_pkg::dp_cmd_t    cmd;
  dro_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  dro_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dro_datapath #(
    .TRIG_BITS (TRIG_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after accepting a beat");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in progress");

  a_colour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.trail_colour <= dro_pkg::ColourStart))
    else $error("trail colour above start level");
`endif

endmodule
